// ===== rtl/pma_pkg.sv =====
// Package for the paged memory allocator and translator.
// Holds the geometry constants, the action type, the sequencer state type and shared widths.
// No dependencies.
package pma_pkg;

  localparam int OFFSET_BITS = 10;
  localparam int ADDR_BITS   = 20;
  localparam int NUM_FRAMES  = 1024;
  localparam int PID_BITS    = 4;

  localparam int FRAME_BITS  = $clog2(NUM_FRAMES);
  localparam int LINK_BITS   = FRAME_BITS + 1;
  localparam int VPAGE_BITS  = ADDR_BITS - OFFSET_BITS;
  localparam int STORE_BITS  = FRAME_BITS + OFFSET_BITS;
  localparam int PROC_COUNT  = 1 << PID_BITS;
  localparam int SIZE_BITS   = 21;
  localparam int BRK_BITS    = 21;
  localparam int PAGES_BITS  = SIZE_BITS + 1 - OFFSET_BITS;
  localparam int FCNT_BITS   = FRAME_BITS + 1;
  localparam int SUM_BITS    = BRK_BITS + 2;

  localparam logic [LINK_BITS-1:0] LINK_END = '1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WRITE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AL_DEC,
    ST_AL_RD,
    ST_AL_CHK,
    ST_AL_END,
    ST_TR_RD,
    ST_TR_CHK,
    ST_FR_LINK,
    ST_FR_LCHK,
    ST_FR_OCHK,
    ST_BY_RD,
    ST_BY_DATA,
    ST_BY_WR,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/pma_ifs.sv =====
// Channel interfaces of the paged memory allocator and translator.
// Depends on pma_pkg for field widths.
interface pma_in_if import pma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [PID_BITS-1:0]    process_id;
  logic [SIZE_BITS-1:0]   request_size;
  logic [ADDR_BITS-1:0]   virtual_address;
  logic [7:0]             write_data;
  modport source (output valid, action, process_id, request_size, virtual_address,
                  write_data, input ready);
  modport sink (input valid, action, process_id, request_size, virtual_address,
                write_data, output ready);
endinterface

interface pma_out_if import pma_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [ADDR_BITS-1:0] alloc_address;
  logic [7:0]           read_data;
  modport source (output valid, status, alloc_address, read_data, input ready);
  modport sink (input valid, status, alloc_address, read_data, output ready);
endinterface

interface pma_cfg_if import pma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BRK_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/pma_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/paged_memory_allocator_translator.sv =====
// Top level of the paged memory allocator and translator.
// Depends on pma_pkg, the channel interfaces in pma_ifs and pma_ram.
//
// Channel  Dir  Payload                                              Beat when
// in_bus   in   action, process_id, request_size, virtual_address,  valid && ready
//              write_data
// out_bus  out  status, alloc_address, read_data                     valid && ready
// cfg_bus  in   data (first_break)                                   valid && ready
//
// Frame table entries are examined one at a time by a single scan sequencer.
// Allocate: a decide state, then a read and a check state per frame scanned
// up to the last frame taken, then an end state. Read, write and free translate
// with a scan of the same kind, then a byte access (read and data states, or a
// write state) or, for free, a link and a link check per frame released, with
// an owner check before each next one. After reset a clearing pass zeroes the
// byte store and the owner table; no input beat is taken meanwhile.
// A finished result waits in the output register; a new beat is taken while
// it waits, and the sequencer stalls only if a second result is ready.
module paged_memory_allocator_translator import pma_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pma_in_if.sink    in_bus,
  pma_out_if.source out_bus,
  pma_cfg_if.sink   cfg_bus
);

  state_t st_r, st_nxt;

  logic [STORE_BITS-1:0] clr_r, clr_nxt;
  logic [FRAME_BITS-1:0] frm_r, frm_nxt;
  logic [FRAME_BITS-1:0] prev_r, prev_nxt;
  logic [PAGES_BITS-1:0] cnt_r, cnt_nxt;
  logic [VPAGE_BITS-1:0] vp_r, vp_nxt;
  logic                  first_r, first_nxt;
  logic [FCNT_BITS-1:0]  free_cnt_r, free_cnt_nxt;

  logic [1:0]            act_r;
  logic [PID_BITS-1:0]   pid_r;
  logic [SIZE_BITS-1:0]  size_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [7:0]            wdata_r;

  logic                  res_status_r, res_status_nxt;
  logic [ADDR_BITS-1:0]  res_addr_r, res_addr_nxt;
  logic [7:0]            res_data_r, res_data_nxt;

  logic                  out_vld_r, out_vld_nxt;
  logic                  out_status_r;
  logic [ADDR_BITS-1:0]  out_addr_r;
  logic [7:0]            out_data_r;

  logic [BRK_BITS-1:0]   first_brk_r;
  logic [BRK_BITS-1:0]   brk_r [PROC_COUNT];
  logic [PROC_COUNT-1:0] brk_vld_r;

  // Table memories.
  logic                  own_we, vpg_we, lnk_we, byt_we;
  logic [FRAME_BITS-1:0] own_wa, own_ra, vpg_wa, lnk_wa, lnk_ra;
  logic [PID_BITS-1:0]   own_wd, own_rd;
  logic [VPAGE_BITS-1:0] vpg_rd;
  logic [LINK_BITS-1:0]  lnk_wd, lnk_rd;
  logic [STORE_BITS-1:0] byt_wa, byt_ra;
  logic [7:0]            byt_wd, byt_rd;

  logic                  in_beat, cfg_beat, fin_load;
  logic [BRK_BITS-1:0]   bp;
  logic [PAGES_BITS-1:0] pages;
  logic [SUM_BITS-1:0]   brk_sum;
  logic                  alloc_ok, tr_hit;

  assign in_beat  = in_bus.valid && in_bus.ready;
  assign cfg_beat = cfg_bus.valid && cfg_bus.ready;
  assign in_bus.ready  = (st_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign fin_load = (st_r == ST_FIN) && (!out_vld_r || out_bus.ready);

  // Break of the current process and the allocate check.
  assign bp      = brk_vld_r[pid_r] ? brk_r[pid_r] : first_brk_r;
  assign pages   = PAGES_BITS'((SUM_BITS'(size_r) + SUM_BITS'((1 << OFFSET_BITS) - 1))
                   >> OFFSET_BITS);
  assign brk_sum = SUM_BITS'(bp) + (SUM_BITS'(pages) << OFFSET_BITS);
  assign alloc_ok = (pid_r != '0) && (pages != '0) &&
                    (PAGES_BITS'(free_cnt_r) >= pages || free_cnt_r[FCNT_BITS-1]) &&
                    (brk_sum <= (SUM_BITS'(1) << ADDR_BITS));
  assign tr_hit  = (own_rd == pid_r) && (vpg_rd == addr_r[ADDR_BITS-1:OFFSET_BITS]);

  pma_ram #(.WIDTH(PID_BITS), .DEPTH(NUM_FRAMES)) u_owner (
    .clk, .we(own_we), .waddr(own_wa), .wdata(own_wd), .raddr(own_ra), .rdata(own_rd)
  );
  pma_ram #(.WIDTH(VPAGE_BITS), .DEPTH(NUM_FRAMES)) u_vpage (
    .clk, .we(vpg_we), .waddr(vpg_wa), .wdata(vp_r), .raddr(frm_r), .rdata(vpg_rd)
  );
  pma_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_FRAMES)) u_link (
    .clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd)
  );
  pma_ram #(.WIDTH(8), .DEPTH(NUM_FRAMES << OFFSET_BITS)) u_bytes (
    .clk, .we(byt_we), .waddr(byt_wa), .wdata(byt_wd), .raddr(byt_ra), .rdata(byt_rd)
  );

  // Next state of the sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:   if (clr_r == '1) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_beat) begin
          if (in_bus.action == ACT_ALLOC) st_nxt = ST_AL_DEC;
          else if (in_bus.process_id == '0) st_nxt = ST_FIN;
          else st_nxt = ST_TR_RD;
        end
      end
      ST_AL_DEC:  st_nxt = alloc_ok ? ST_AL_RD : ST_FIN;
      ST_AL_RD:   st_nxt = ST_AL_CHK;
      ST_AL_CHK:  st_nxt = (own_rd == '0 && cnt_r == PAGES_BITS'(1)) ? ST_AL_END : ST_AL_RD;
      ST_AL_END:  st_nxt = ST_FIN;
      ST_TR_RD:   st_nxt = ST_TR_CHK;
      ST_TR_CHK: begin
        if (tr_hit) begin
          unique case (act_r)
            ACT_FREE:  st_nxt = ST_FR_LINK;
            ACT_READ:  st_nxt = ST_BY_RD;
            default:   st_nxt = ST_BY_WR;
          endcase
        end else if (frm_r == '1) begin
          st_nxt = ST_FIN;
        end else begin
          st_nxt = ST_TR_RD;
        end
      end
      ST_FR_LINK: st_nxt = ST_FR_LCHK;
      ST_FR_LCHK: st_nxt = lnk_rd[LINK_BITS-1] ? ST_FIN : ST_FR_OCHK;
      ST_FR_OCHK: st_nxt = (own_rd == pid_r) ? ST_FR_LINK : ST_FIN;
      ST_BY_RD:   st_nxt = ST_BY_DATA;
      ST_BY_DATA: st_nxt = ST_FIN;
      ST_BY_WR:   st_nxt = ST_FIN;
      ST_FIN:     if (fin_load) st_nxt = ST_IDLE;
      default:    st_nxt = ST_CLEAR;
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    clr_nxt        = clr_r;
    frm_nxt        = frm_r;
    prev_nxt       = prev_r;
    cnt_nxt        = cnt_r;
    vp_nxt         = vp_r;
    first_nxt      = first_r;
    free_cnt_nxt   = free_cnt_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_data_nxt   = res_data_r;
    own_we = 1'b0;
    own_wa = frm_r;
    own_wd = '0;
    own_ra = frm_r;
    vpg_we = 1'b0;
    vpg_wa = frm_r;
    lnk_we = 1'b0;
    lnk_wa = prev_r;
    lnk_wd = LINK_BITS'(frm_r);
    lnk_ra = frm_r;
    byt_we = 1'b0;
    byt_wa = {frm_r, addr_r[OFFSET_BITS-1:0]};
    byt_wd = wdata_r;
    byt_ra = {frm_r, addr_r[OFFSET_BITS-1:0]};
    unique case (st_r)
      ST_CLEAR: begin
        byt_we  = 1'b1;
        byt_wa  = clr_r;
        byt_wd  = '0;
        own_we  = (clr_r[STORE_BITS-1:FRAME_BITS] == '0);
        own_wa  = clr_r[FRAME_BITS-1:0];
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        frm_nxt        = '0;
        res_status_nxt = 1'b1;
        res_addr_nxt   = '0;
        res_data_nxt   = '0;
      end
      ST_AL_DEC: begin
        cnt_nxt   = pages;
        vp_nxt    = bp[ADDR_BITS-1:OFFSET_BITS];
        first_nxt = 1'b1;
        if (alloc_ok) begin
          res_status_nxt = 1'b0;
          res_addr_nxt   = bp[ADDR_BITS-1:0];
          free_cnt_nxt   = free_cnt_r - FCNT_BITS'(pages);
        end
      end
      ST_AL_CHK: begin
        if (own_rd == '0) begin
          own_we    = 1'b1;
          own_wd    = pid_r;
          vpg_we    = 1'b1;
          lnk_we    = !first_r;
          prev_nxt  = frm_r;
          first_nxt = 1'b0;
          vp_nxt    = vp_r + 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
        frm_nxt = frm_r + 1'b1;
      end
      ST_AL_END: begin
        lnk_we = 1'b1;
        lnk_wd = LINK_END;
      end
      ST_TR_CHK: begin
        if (tr_hit) res_status_nxt = 1'b0;
        else frm_nxt = frm_r + 1'b1;
      end
      ST_FR_LINK: begin
        own_we       = 1'b1;
        free_cnt_nxt = free_cnt_r + 1'b1;
      end
      ST_FR_LCHK: begin
        own_ra  = lnk_rd[FRAME_BITS-1:0];
        frm_nxt = lnk_rd[FRAME_BITS-1:0];
      end
      ST_BY_DATA: res_data_nxt = byt_rd;
      ST_BY_WR:   byt_we = 1'b1;
      default: ;
    endcase
  end

  // Output register.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_bus.ready) out_vld_nxt = 1'b0;
    if (fin_load) out_vld_nxt = 1'b1;
  end

  assign out_bus.valid         = out_vld_r;
  assign out_bus.status        = out_status_r;
  assign out_bus.alloc_address = out_addr_r;
  assign out_bus.read_data     = out_data_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      out_vld_r   <= 1'b0;
      free_cnt_r  <= FCNT_BITS'(NUM_FRAMES);
      brk_vld_r   <= '0;
      first_brk_r <= BRK_BITS'(1024);
    end else begin
      st_r       <= st_nxt;
      clr_r      <= clr_nxt;
      out_vld_r  <= out_vld_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (cfg_beat) begin
        first_brk_r <= cfg_bus.data;
        brk_vld_r   <= '0;
      end else if (st_r == ST_AL_DEC && alloc_ok) begin
        brk_vld_r[pid_r] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    frm_r        <= frm_nxt;
    prev_r       <= prev_nxt;
    cnt_r        <= cnt_nxt;
    vp_r         <= vp_nxt;
    first_r      <= first_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_data_r   <= res_data_nxt;
    if (in_beat) begin
      act_r   <= in_bus.action;
      pid_r   <= in_bus.process_id;
      size_r  <= in_bus.request_size;
      addr_r  <= in_bus.virtual_address;
      wdata_r <= in_bus.write_data;
    end
    if (st_r == ST_AL_DEC && alloc_ok) begin
      brk_r[pid_r] <= brk_sum[BRK_BITS-1:0];
    end
    if (fin_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_data_r   <= res_data_r;
    end
  end

  // Checks on the sequencer.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |-> !out_vld_r) else $error("result during clearing pass");
  a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= FCNT_BITS'(NUM_FRAMES)) else $error("free frame count overflow");
  a_beat_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> st_r != ST_IDLE) else $error("accepted beat left sequencer idle");
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_FIN && out_vld_r && !out_bus.ready |=> st_r == ST_FIN)
    else $error("result dropped while output busy");

endmodule

// ===== sim/tb_paged_memory_allocator_translator.sv =====
// Self-checking testbench for paged_memory_allocator_translator.
// Uses pma_pkg and the channel interfaces in pma_ifs; the expected results
// come from a page table and byte store mirrored inside this file.
`timescale 1ns / 100ps

module tb_paged_memory_allocator_translator;
  import pma_pkg::*;

  localparam int unsigned PG_BYTES    = 1 << OFFSET_BITS;
  localparam int unsigned ADDR_SPAN   = 1 << ADDR_BITS;
  localparam int unsigned QUIET_LIMIT = 4000000;
  localparam int unsigned ITEM_COUNT  = 1850;
  localparam int unsigned PHASES      = 7;

  typedef struct {
    action_t              act;
    logic [PID_BITS-1:0]  pid;
    logic [SIZE_BITS-1:0] size;
    logic [ADDR_BITS-1:0] vaddr;
    logic [7:0]           wdata;
  } mem_request_t;

  typedef struct packed {
    logic                 status;
    logic [ADDR_BITS-1:0] alloc_address;
    logic [7:0]           read_data;
  } mem_reply_t;

  logic clk;
  logic rst_n;

  pma_in_if  in_bus ();
  pma_out_if out_bus ();
  pma_cfg_if cfg_bus ();

  paged_memory_allocator_translator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Mirror of the allocator state.
  logic [PID_BITS-1:0]   owner_of   [NUM_FRAMES];
  logic [VPAGE_BITS-1:0] vpage_of   [NUM_FRAMES];
  int unsigned           link_of    [NUM_FRAMES];
  logic [BRK_BITS-1:0]   brk_of     [PROC_COUNT];
  logic [7:0]            phys_bytes [int unsigned];
  logic [BRK_BITS-1:0]   start_brk;
  int unsigned           free_frames;

  mem_request_t pending_requests[$];
  mem_reply_t   expected_replies[$];
  int unsigned  requests_queued, requests_taken;
  int unsigned  mismatches;
  logic         in_fire;
  int unsigned  gap_left, burst_left;
  bit           sender_calm;
  logic [15:0]  stall_pattern;
  int unsigned  quiet_cycles;

  always #6 clk = ~clk;

  // Returns the lowest frame that pid maps at vaddr, or -1.
  function automatic int lookup_frame(logic [PID_BITS-1:0] pid, logic [ADDR_BITS-1:0] vaddr);
    for (int f = 0; f < NUM_FRAMES; f++)
      if (owner_of[f] == pid && vpage_of[f] == vaddr[ADDR_BITS-1:OFFSET_BITS])
        return f;
    return -1;
  endfunction

  function automatic void load_start_break(logic [BRK_BITS-1:0] value);
    start_brk = value;
    for (int p = 0; p < PROC_COUNT; p++) brk_of[p] = value;
  endfunction

  // Applies one request to the mirror and returns the reply it must cause.
  function automatic mem_reply_t apply_request(mem_request_t rq);
    mem_reply_t  rp;
    int unsigned pages, done, prev, cur, nxt, phys;
    longint      bp;
    int          fr;
    rp = '{status: 1'b1, alloc_address: '0, read_data: '0};
    if (rq.pid == 0) return rp;
    if (rq.act == ACT_ALLOC) begin
      pages = (int'(rq.size) + PG_BYTES - 1) >> OFFSET_BITS;
      bp = brk_of[rq.pid];
      if (pages != 0 && free_frames >= pages && bp + longint'(pages) * PG_BYTES <= ADDR_SPAN)
      begin
        done = 0;
        prev = 0;
        for (int f = 0; f < NUM_FRAMES && done < pages; f++) begin
          if (owner_of[f] == 0) begin
            owner_of[f] = rq.pid;
            vpage_of[f] = VPAGE_BITS'((bp + longint'(done) * PG_BYTES) >> OFFSET_BITS);
            link_of[f] = LINK_END;
            if (done != 0) link_of[prev] = f;
            prev = f;
            done++;
          end
        end
        free_frames -= pages;
        rp.alloc_address = bp[ADDR_BITS-1:0];
        brk_of[rq.pid] = BRK_BITS'(bp + longint'(pages) * PG_BYTES);
        rp.status = 1'b0;
      end
      return rp;
    end
    fr = lookup_frame(rq.pid, rq.vaddr);
    if (fr < 0) return rp;
    rp.status = 1'b0;
    phys = (fr << OFFSET_BITS) | (rq.vaddr & (PG_BYTES - 1));
    case (rq.act)
      ACT_FREE: begin
        // Release along the run until its end or a frame owned by someone else.
        cur = fr;
        for (int s = 0; s < NUM_FRAMES; s++) begin
          nxt = link_of[cur];
          owner_of[cur] = '0;
          free_frames++;
          if (nxt >= NUM_FRAMES || owner_of[nxt] != rq.pid) break;
          cur = nxt;
        end
      end
      ACT_READ: begin
        rp.read_data = phys_bytes.exists(phys) ? phys_bytes[phys] : 8'h00;
      end
      default: begin
        phys_bytes[phys] = rq.wdata;
      end
    endcase
    return rp;
  endfunction

  // Input side: every accepted beat is applied to the mirror at once.
  always @(posedge clk) begin
    in_fire <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      expected_replies.push_back(apply_request('{act: action_t'(in_bus.action),
        pid: in_bus.process_id, size: in_bus.request_size,
        vaddr: in_bus.virtual_address, wdata: in_bus.write_data}));
      requests_taken++;
    end
  end

  // Result side: compare each beat with the oldest expectation.
  always @(posedge clk) begin
    mem_reply_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat status=%0d addr=%h data=%h",
                   out_bus.status, out_bus.alloc_address, out_bus.read_data);
      end else begin
        exp_r = expected_replies.pop_front();
        if (exp_r.status !== out_bus.status || exp_r.alloc_address !== out_bus.alloc_address ||
            exp_r.read_data !== out_bus.read_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result mismatch: expected status=%0d addr=%h data=%h, ",
                      "got status=%0d addr=%h data=%h"},
                     exp_r.status, exp_r.alloc_address, exp_r.read_data,
                     out_bus.status, out_bus.alloc_address, out_bus.read_data);
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps, or by none in calm phases.
  always @(negedge clk) begin
    mem_request_t rq;
    if (rst_n && (!in_bus.valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        rq = pending_requests.pop_front();
        in_bus.action          <= rq.act;
        in_bus.process_id      <= rq.pid;
        in_bus.request_size    <= rq.size;
        in_bus.virtual_address <= rq.vaddr;
        in_bus.write_data      <= rq.wdata;
        in_bus.valid           <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 8);
          gap_left = sender_calm ? 0 : $urandom_range(0, 20);
        end else begin
          burst_left--;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls follow a rotating pattern that is replaced now and then.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0)
      stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
    out_bus.ready <= stall_pattern[0];
  end

  // Watchdog on cycles without any beat; covers the clearing pass after reset.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("paged_memory_allocator_translator test failed");
      $finish;
    end
  end

  task automatic queue_request(action_t act, int pid, int unsigned size, int unsigned vaddr,
                               int unsigned wdata);
    pending_requests.push_back('{act: act, pid: PID_BITS'(pid), size: SIZE_BITS'(size),
                                 vaddr: ADDR_BITS'(vaddr), wdata: 8'(wdata)});
    requests_queued++;
  endtask

  task automatic wait_for_idle();
    while (requests_taken != requests_queued || expected_replies.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_start_break(int unsigned value);
    wait_for_idle();
    @(negedge clk);
    cfg_bus.data  <= BRK_BITS'(value);
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    load_start_break(BRK_BITS'(value));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // One random request; mostly aimed at pages that the process really owns.
  task automatic queue_random_request();
    int unsigned pick, pid, start, vaddr;
    int          hit;
    pick = $urandom_range(0, 99);
    pid = $urandom_range(1, PROC_COUNT - 1);
    if (pick < 4) begin
      queue_request(action_t'($urandom_range(0, 3)), $urandom_range(0, PROC_COUNT - 1),
                    $urandom_range(0, (1 << SIZE_BITS) - 1), $urandom, $urandom);
    end else if (pick < 30) begin
      queue_request(ACT_ALLOC, pid, ($urandom_range(0, 9) == 0) ?
                    $urandom_range(0, (1 << SIZE_BITS) - 1) : $urandom_range(1, 4096),
                    $urandom, $urandom);
    end else begin
      hit = -1;
      start = $urandom_range(0, NUM_FRAMES - 1);
      for (int k = 0; k < NUM_FRAMES && hit < 0; k++)
        if (owner_of[(start + k) % NUM_FRAMES] == pid) hit = (start + k) % NUM_FRAMES;
      if (hit >= 0 && $urandom_range(0, 9) != 0)
        vaddr = (int'(vpage_of[hit]) << OFFSET_BITS) | $urandom_range(0, PG_BYTES - 1);
      else
        vaddr = $urandom_range(0, ADDR_SPAN - 1);
      pick = $urandom_range(0, 9);
      queue_request(pick < 2 ? ACT_FREE : (pick < 6 ? ACT_READ : ACT_WRITE), pid, $urandom,
                    vaddr, $urandom);
    end
  endtask

  initial begin
    int unsigned start_values[PHASES];
    clk = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_ALLOC;
    in_bus.process_id = '0;
    in_bus.request_size = '0;
    in_bus.virtual_address = '0;
    in_bus.write_data = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    in_fire = 1'b0;
    stall_pattern = 16'hA5F3;
    sender_calm = 1'b0;
    gap_left = 0;
    burst_left = 0;
    quiet_cycles = 0;
    requests_queued = 0;
    requests_taken = 0;
    mismatches = 0;
    free_frames = NUM_FRAMES;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      owner_of[f] = '0;
      vpage_of[f] = '0;
      link_of[f] = 0;
    end
    load_start_break(BRK_BITS'(1024));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the start break left at its reset value.
    queue_request(ACT_ALLOC, 1, 1, 0, 0);
    queue_request(ACT_ALLOC, 1, 0, 0, 0);                 // zero size fails
    queue_request(ACT_ALLOC, 0, 4096, 0, 0);              // reserved process
    queue_request(ACT_WRITE, 1, 0, 1024, 8'hFF);
    queue_request(ACT_WRITE, 1, 0, 2047, 8'h5A);
    queue_request(ACT_READ, 1, 0, 1024, 0);
    queue_request(ACT_READ, 1, 0, 2047, 0);
    queue_request(ACT_READ, 1, 0, 0, 0);                  // unmapped
    queue_request(ACT_ALLOC, 15, 1 << 20, 0, 0);          // break would overflow
    queue_request(ACT_ALLOC, 2, (1 << SIZE_BITS) - 1, 0, 0);
    queue_request(ACT_ALLOC, 2, 5000, 0, 0);              // five linked pages
    queue_request(ACT_WRITE, 2, 0, 3 * 1024 + 7, 8'h81);
    queue_request(ACT_FREE, 2, 0, 4 * 1024 + 9, 0);       // frees the tail of the run
    queue_request(ACT_READ, 2, 0, 5 * 1024, 0);
    queue_request(ACT_READ, 2, 0, 3 * 1024 + 7, 0);
    queue_request(ACT_ALLOC, 4, 3000, 0, 0);              // reuses the freed frames
    queue_request(ACT_FREE, 2, 0, 1024, 0);               // walk stops at a foreign frame
    queue_request(ACT_READ, 4, 0, 1024 + 3, 0);
    queue_request(ACT_FREE, 1, 0, 1500, 0);
    queue_request(ACT_FREE, 1, 0, 1500, 0);               // already freed
    queue_request(ACT_WRITE, 0, 0, 1024, 8'h11);
    queue_request(ACT_ALLOC, 3, 1023, 0, 0);
    queue_request(ACT_READ, 15, 0, (1 << ADDR_BITS) - 1, 0);

    // Random phases, each under its own start break; the pause before every
    // register write also drains the block completely.
    start_values = '{0, 1 << 20, 1000, 1023 * 1024, (1 << 20) - 4096,
                     $urandom_range(0, 1023) * 1024, $urandom_range(0, 1 << 20)};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_start_break(start_values[ph]);
      sender_calm = (ph % 3 == 1);
      for (int n = 0; n < ITEM_COUNT / PHASES; n++) begin
        while (pending_requests.size() > 2) @(posedge clk);
        #1;
        queue_random_request();
      end
    end

    wait_for_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("paged_memory_allocator_translator test passed");
    else
      $display("paged_memory_allocator_translator test failed");
    $finish;
  end

endmodule
